// File: design/deu_pkg.sv
// Shared constants, register codes and field widths for the dual encoder unwrap block.
package deu_pkg;

  localparam int unsigned COUNTS_PER_TURN = 4096;
  localparam int unsigned POSITION_BITS   = 32;

  localparam int unsigned FRAME_W    = 24;
  localparam int unsigned COUNT_W    = 12;
  localparam int unsigned COUNT_LSB  = 11;
  localparam int unsigned THR_W      = 12;
  localparam int unsigned REV_W      = 2;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned VEL_W      = 37;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned NUM_CH     = 2;

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(1000);
  localparam logic [REV_W-1:0]  REV_RESET  = REV_W'(1);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROLLOVER_THRESHOLD = 2'd0,
    REG_REVERSE_MASK       = 2'd1,
    REG_VELOCITY_GAIN      = 2'd2
  } cfg_reg_e;

  // Channel slots inside the per-channel arrays.
  localparam int unsigned CH_LEFT  = 0;
  localparam int unsigned CH_RIGHT = 1;

  function automatic logic [COUNT_W-1:0] frame_count(input logic [FRAME_W-1:0] frame);
    return frame[COUNT_LSB +: COUNT_W];
  endfunction

endpackage

// File: design/dual_encoder_position_unwrap.sv
// Top level of the dual encoder multiturn unwrap: input stage, update stage, result register.
// An item is registered in the input stage, then in the result register once that one is free.
// Throughput: one item per cycle unless the result side stalls; the update is combinational.
// While a result waits, one more item is still taken into the input register.
// Reset: asynchronous, active low; configuration returns to its defaults, positions and previous
// counts clear to zero, and the next item is handled as the first sample.
module dual_encoder_position_unwrap #(
  parameter int unsigned CountsPerTurn = deu_pkg::COUNTS_PER_TURN,
  parameter int unsigned PositionBits  = deu_pkg::POSITION_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,

  input  logic                                  cfg_we_i,
  input  logic [deu_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [deu_pkg::CFG_DATA_W-1:0]        cfg_data_i,

  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [deu_pkg::FRAME_W-1:0]           left_frame_i,
  input  logic [deu_pkg::FRAME_W-1:0]           right_frame_i,

  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [deu_pkg::COUNT_W-1:0]           left_count_o,
  output logic [deu_pkg::COUNT_W-1:0]           right_count_o,
  output logic signed [PositionBits-1:0]        left_position_o,
  output logic signed [PositionBits-1:0]        right_position_o,
  output logic signed [deu_pkg::VEL_W-1:0]      left_velocity_o,
  output logic signed [deu_pkg::VEL_W-1:0]      right_velocity_o
);

  localparam int unsigned CountW = deu_pkg::COUNT_W;
  localparam int unsigned NumCh  = deu_pkg::NUM_CH;
  localparam int unsigned DeltaW = $clog2(CountsPerTurn + 2 ** CountW) + 1;
  localparam int unsigned ProdW  = DeltaW + deu_pkg::GAIN_W + 1;
  localparam int unsigned SumW   = PositionBits + 1;
  localparam logic signed [DeltaW-1:0] Turn = DeltaW'(CountsPerTurn);
  localparam logic signed [PositionBits-1:0] PosMax = {1'b0, {(PositionBits-1){1'b1}}};
  localparam logic signed [PositionBits-1:0] PosMin = {1'b1, {(PositionBits-1){1'b0}}};

  // Configuration registers.
  logic [deu_pkg::THR_W-1:0]  thr_q;
  logic [deu_pkg::REV_W-1:0]  rev_q;
  logic [deu_pkg::GAIN_W-1:0] gain_q;

  // Input stage.
  logic              s1_valid_q;
  logic [CountW-1:0] s1_cnt_q [NumCh];
  logic              s1_adv;

  // Channel state.
  logic                           first_q;
  logic [CountW-1:0]              prev_q [NumCh];
  logic signed [PositionBits-1:0] acc_q  [NumCh];

  // Result register.
  logic                              out_valid_q;
  logic [CountW-1:0]                 out_cnt_q [NumCh];
  logic signed [PositionBits-1:0]    out_pos_q [NumCh];
  logic signed [deu_pkg::VEL_W-1:0]  out_vel_q [NumCh];

  logic signed [PositionBits-1:0]   pos_d [NumCh];
  logic signed [deu_pkg::VEL_W-1:0] vel_d [NumCh];

  // Signed count step, with a step above the threshold taken as a wrap past zero.
  function automatic logic signed [DeltaW-1:0] unwrap(
    input logic [CountW-1:0]          cur,
    input logic [CountW-1:0]          prev,
    input logic [deu_pkg::THR_W-1:0]  thr
  );
    logic signed [CountW:0]   diff;
    logic [CountW-1:0]        mag;
    logic signed [DeltaW-1:0] d;
    diff = $signed({1'b0, cur}) - $signed({1'b0, prev});
    mag  = diff[CountW] ? CountW'(-diff) : diff[CountW-1:0];
    d    = DeltaW'(diff);
    if (mag > CountW'(thr)) begin
      d = (cur > prev) ? d - Turn : d + Turn;
    end
    return d;
  endfunction

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= deu_pkg::THR_RESET;
      rev_q  <= deu_pkg::REV_RESET;
      gain_q <= deu_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        deu_pkg::REG_ROLLOVER_THRESHOLD: thr_q  <= cfg_data_i[deu_pkg::THR_W-1:0];
        deu_pkg::REG_REVERSE_MASK:       rev_q  <= cfg_data_i[deu_pkg::REV_W-1:0];
        deu_pkg::REG_VELOCITY_GAIN:      gain_q <= cfg_data_i[deu_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_cnt_q[deu_pkg::CH_LEFT]  <= deu_pkg::frame_count(left_frame_i);
      s1_cnt_q[deu_pkg::CH_RIGHT] <= deu_pkg::frame_count(right_frame_i);
    end
  end

  for (genvar ch = 0; ch < NumCh; ch++) begin : g_ch
    logic signed [DeltaW-1:0] delta;
    logic signed [DeltaW-1:0] dsel;
    logic signed [SumW-1:0]   sum;
    logic signed [ProdW-1:0]  prod;

    always_comb begin
      delta = unwrap(s1_cnt_q[ch], prev_q[ch], thr_q);
      dsel  = rev_q[ch] ? -delta : delta;
      sum   = SumW'(acc_q[ch]) + SumW'(dsel);
      prod  = ProdW'(dsel) * $signed({1'b0, gain_q});
      if (first_q) begin
        pos_d[ch] = PositionBits'(s1_cnt_q[ch]);
        vel_d[ch] = '0;
      end else begin
        // Top two bits of the widened sum disagree only on overflow.
        if (sum[SumW-1] != sum[SumW-2]) begin
          pos_d[ch] = sum[SumW-1] ? PosMin : PosMax;
        end else begin
          pos_d[ch] = sum[PositionBits-1:0];
        end
        vel_d[ch] = prod[deu_pkg::VEL_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        prev_q[ch] <= '0;
        acc_q[ch]  <= '0;
      end else if (s1_adv) begin
        prev_q[ch] <= s1_cnt_q[ch];
        acc_q[ch]  <= pos_d[ch];
      end
    end

    always_ff @(posedge clk_i) begin
      if (s1_adv) begin
        out_cnt_q[ch] <= s1_cnt_q[ch];
        out_pos_q[ch] <= pos_d[ch];
        out_vel_q[ch] <= vel_d[ch];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        first_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign left_count_o     = out_cnt_q[deu_pkg::CH_LEFT];
  assign right_count_o    = out_cnt_q[deu_pkg::CH_RIGHT];
  assign left_position_o  = out_pos_q[deu_pkg::CH_LEFT];
  assign right_position_o = out_pos_q[deu_pkg::CH_RIGHT];
  assign left_velocity_o  = out_vel_q[deu_pkg::CH_LEFT];
  assign right_velocity_o = out_vel_q[deu_pkg::CH_RIGHT];

endmodule

// File: tb/tb_dual_encoder_position_unwrap.sv
// Self-checking testbench for the dual encoder multiturn unwrap, checked against a local predictor.
module tb_dual_encoder_position_unwrap;

  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 320;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned LARGE_STEPS = 12;
  localparam logic [deu_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint POS_MAX = (longint'(1) <<< (deu_pkg::POSITION_BITS - 1)) - 1;
  localparam longint POS_MIN = -POS_MAX - 1;

  typedef struct packed {
    logic [deu_pkg::COUNT_W-1:0]              left_count;
    logic [deu_pkg::COUNT_W-1:0]              right_count;
    logic signed [deu_pkg::POSITION_BITS-1:0] left_position;
    logic signed [deu_pkg::POSITION_BITS-1:0] right_position;
    logic signed [deu_pkg::VEL_W-1:0]         left_velocity;
    logic signed [deu_pkg::VEL_W-1:0]         right_velocity;
  } unwrap_result_t;

  logic                                     clk_i         = 1'b0;
  logic                                     rst_ni        = 1'b0;
  logic                                     cfg_we_i      = 1'b0;
  logic [deu_pkg::CFG_IDX_W-1:0]            cfg_index_i   = '0;
  logic [deu_pkg::CFG_DATA_W-1:0]           cfg_data_i    = '0;
  logic                                     in_valid_i    = 1'b0;
  logic                                     in_ready_o;
  logic [deu_pkg::FRAME_W-1:0]              left_frame_i  = '0;
  logic [deu_pkg::FRAME_W-1:0]              right_frame_i = '0;
  logic                                     out_valid_o;
  logic                                     out_ready_i   = 1'b0;
  logic [deu_pkg::COUNT_W-1:0]              left_count_o;
  logic [deu_pkg::COUNT_W-1:0]              right_count_o;
  logic signed [deu_pkg::POSITION_BITS-1:0] left_position_o;
  logic signed [deu_pkg::POSITION_BITS-1:0] right_position_o;
  logic signed [deu_pkg::VEL_W-1:0]         left_velocity_o;
  logic signed [deu_pkg::VEL_W-1:0]         right_velocity_o;

  dual_encoder_position_unwrap dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .left_frame_i     (left_frame_i),
    .right_frame_i    (right_frame_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .left_count_o     (left_count_o),
    .right_count_o    (right_count_o),
    .left_position_o  (left_position_o),
    .right_position_o (right_position_o),
    .left_velocity_o  (left_velocity_o),
    .right_velocity_o (right_velocity_o)
  );

  // Predictor copy of the registers and channel state.
  logic [deu_pkg::THR_W-1:0]   thr_q         = deu_pkg::THR_RESET;
  logic [deu_pkg::REV_W-1:0]   rev_q         = deu_pkg::REV_RESET;
  logic [deu_pkg::GAIN_W-1:0]  gain_q        = deu_pkg::GAIN_RESET;
  logic                        first_pending = 1'b1;
  logic [deu_pkg::COUNT_W-1:0] lprev_q       = '0;
  logic [deu_pkg::COUNT_W-1:0] rprev_q       = '0;
  longint                      lacc_q        = 0;
  longint                      racc_q        = 0;

  unwrap_result_t expected_results[$];
  int unsigned    mismatch_count = 0;
  int unsigned    result_index   = 0;
  int unsigned    idle_cycles    = 0;
  int unsigned    send_idle_pct  = 0;
  int unsigned    stall_pct      = 0;
  int unsigned    hold_req       = 0;
  int unsigned    hold_left      = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unwrapped_delta(input logic [deu_pkg::COUNT_W-1:0] cur,
                                             input logic [deu_pkg::COUNT_W-1:0] prev,
                                             input logic reversed);
    longint d;
    d = longint'(cur) - longint'(prev);
    if ((d < 0 ? -d : d) > longint'(thr_q)) begin
      d = (cur > prev) ? d - longint'(deu_pkg::COUNTS_PER_TURN)
                       : d + longint'(deu_pkg::COUNTS_PER_TURN);
    end
    return reversed ? -d : d;
  endfunction

  function automatic longint clamp_position(input longint s);
    return (s > POS_MAX) ? POS_MAX : ((s < POS_MIN) ? POS_MIN : s);
  endfunction

  function automatic unwrap_result_t unwrap_step(input logic [deu_pkg::FRAME_W-1:0] lf,
                                                 input logic [deu_pkg::FRAME_W-1:0] rf);
    unwrap_result_t r;
    logic [deu_pkg::COUNT_W-1:0] lc;
    logic [deu_pkg::COUNT_W-1:0] rc;
    longint ld;
    longint rd;
    longint lv;
    longint rv;
    lc = lf[deu_pkg::COUNT_LSB +: deu_pkg::COUNT_W];
    rc = rf[deu_pkg::COUNT_LSB +: deu_pkg::COUNT_W];
    if (first_pending) begin
      // The first sample loads the raw counts, with no reversal applied.
      ld = 0;
      rd = 0;
      lacc_q = clamp_position(longint'(lc));
      racc_q = clamp_position(longint'(rc));
    end else begin
      ld = unwrapped_delta(lc, lprev_q, rev_q[deu_pkg::CH_LEFT]);
      rd = unwrapped_delta(rc, rprev_q, rev_q[deu_pkg::CH_RIGHT]);
      lacc_q = clamp_position(lacc_q + ld);
      racc_q = clamp_position(racc_q + rd);
    end
    first_pending = 1'b0;
    lprev_q = lc;
    rprev_q = rc;
    lv = ld * longint'(gain_q);
    rv = rd * longint'(gain_q);
    r.left_count     = lc;
    r.right_count    = rc;
    r.left_position  = lacc_q[deu_pkg::POSITION_BITS-1:0];
    r.right_position = racc_q[deu_pkg::POSITION_BITS-1:0];
    r.left_velocity  = lv[deu_pkg::VEL_W-1:0];
    r.right_velocity = rv[deu_pkg::VEL_W-1:0];
    return r;
  endfunction

  function automatic logic [deu_pkg::FRAME_W-1:0] make_frame(
    input logic [deu_pkg::COUNT_W-1:0] cnt
  );
    logic [deu_pkg::FRAME_W-1:0] f;
    f = deu_pkg::FRAME_W'($urandom);
    f[deu_pkg::COUNT_LSB +: deu_pkg::COUNT_W] = cnt;
    return f;
  endfunction

  // Steps include the rollover threshold and one past it, where the unwrap decision flips.
  function automatic logic [deu_pkg::COUNT_W-1:0] next_count(
    input logic [deu_pkg::COUNT_W-1:0] prev
  );
    int step;
    case ($urandom_range(5))
      0:       return deu_pkg::COUNT_W'($urandom);
      1:       step = int'($urandom_range(16)) - 8;
      2:       step = int'(thr_q);
      3:       step = int'(thr_q) + 1;
      4:       step = int'($urandom_range(thr_q));
      default: step = 0;
    endcase
    if ($urandom_range(1)) step = -step;
    return prev + step[deu_pkg::COUNT_W-1:0];
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic compare_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (got !== want) begin
      note_failure($sformatf("result %0d %s: expected %0d, got %0d",
                             result_index, name, want, got));
    end
  endtask

  task automatic send_frames(input logic [deu_pkg::FRAME_W-1:0] lf,
                             input logic [deu_pkg::FRAME_W-1:0] rf);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i    <= 1'b1;
    left_frame_i  <= lf;
    right_frame_i <= rf;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(unwrap_step(lf, rf));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [deu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [deu_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      deu_pkg::REG_ROLLOVER_THRESHOLD: thr_q  = data[deu_pkg::THR_W-1:0];
      deu_pkg::REG_REVERSE_MASK:       rev_q  = data[deu_pkg::REV_W-1:0];
      deu_pkg::REG_VELOCITY_GAIN:      gain_q = data[deu_pkg::GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [deu_pkg::THR_W-1:0] thr,
                           input logic [deu_pkg::REV_W-1:0] rev,
                           input logic [deu_pkg::GAIN_W-1:0] gain);
    logic [deu_pkg::CFG_DATA_W-1:0] data;
    wait_idle();
    // Bits above a register's width carry noise that the block must drop.
    data = deu_pkg::CFG_DATA_W'($urandom);
    data[deu_pkg::THR_W-1:0] = thr;
    write_reg(deu_pkg::REG_ROLLOVER_THRESHOLD, data);
    data = deu_pkg::CFG_DATA_W'($urandom);
    data[deu_pkg::REV_W-1:0] = rev;
    write_reg(deu_pkg::REG_REVERSE_MASK, data);
    write_reg(deu_pkg::REG_VELOCITY_GAIN, gain);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed_defaults();
    // First sample at the frame extremes, then a zero step with the unused bits flipped.
    send_frames(24'hFFFFFF, 24'h000000);
    send_frames({1'b0, 12'hFFF, 11'h000}, {1'b1, 12'h000, 11'h7FF});
    send_frames(make_frame(12'd5), make_frame(12'd4090));
    send_frames(make_frame(12'd1005), make_frame(12'd3090));
    send_frames(make_frame(12'd2006), make_frame(12'd2089));
    send_frames(make_frame(12'd2009), make_frame(12'd2086));
  endtask

  task automatic test_register_extremes();
    // A zero threshold turns every nonzero step into a wrap.
    configure(12'd0, 2'b11, 24'hFFFFFF);
    send_frames(make_frame(lprev_q + 1'b1), make_frame(rprev_q - 1'b1));
    send_frames(make_frame(lprev_q), make_frame(rprev_q));
    send_frames(make_frame(lprev_q - 1'b1), make_frame(rprev_q + 1'b1));
    configure(12'd4095, 2'b00, 24'd0);
    send_frames(make_frame(12'h000), make_frame(12'hFFF));
    send_frames(make_frame(12'hFFF), make_frame(12'h000));
    send_frames(make_frame(12'h000), make_frame(12'hFFF));
    // A write to the unused index must leave every register as it was.
    wait_idle();
    write_reg(REG_UNUSED, 24'hFFFFFF);
    cfg_we_i <= 1'b0;
    send_frames(make_frame(12'h800), make_frame(12'h7FF));
    send_frames(make_frame(12'h001), make_frame(12'hFFE));
  endtask

  task automatic test_full_turn_steps();
    configure(12'd0, 2'b00, deu_pkg::GAIN_W'($urandom));
    // One count back unwraps to nearly a full turn forward, so the left position climbs by
    // almost a turn per item while the right one falls by as much; then both turn around.
    repeat (LARGE_STEPS) begin
      send_frames(make_frame(lprev_q - 1'b1), make_frame(rprev_q + 1'b1));
    end
    repeat (3) send_frames(make_frame(lprev_q + 1'b1), make_frame(rprev_q - 1'b1));
  endtask

  task automatic test_back_pressure();
    configure(deu_pkg::THR_RESET, deu_pkg::REV_RESET, deu_pkg::GAIN_RESET);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = HOLD_CYCLES;
    repeat (24) send_frames(make_frame(next_count(lprev_q)), make_frame(next_count(rprev_q)));
    // The sender then waits for every outstanding result.
    wait_idle();
  endtask

  task automatic run_traffic_phase(input int unsigned idle_pct, input int unsigned stall);
    logic [deu_pkg::THR_W-1:0]  thr;
    logic [deu_pkg::GAIN_W-1:0] gain;
    case ($urandom_range(3))
      0:       thr = deu_pkg::THR_W'($urandom_range(15));
      1:       thr = deu_pkg::THR_W'(4095 - $urandom_range(15));
      default: thr = deu_pkg::THR_W'($urandom);
    endcase
    case ($urandom_range(3))
      0:       gain = '1;
      1:       gain = deu_pkg::GAIN_RESET;
      default: gain = deu_pkg::GAIN_W'($urandom);
    endcase
    configure(thr, deu_pkg::REV_W'($urandom), gain);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (PHASE_ITEMS) begin
      send_frames(make_frame(next_count(lprev_q)), make_frame(next_count(rprev_q)));
    end
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(0, 0);
    run_traffic_phase(72, 0);
    run_traffic_phase(0, 72);
    run_traffic_phase(17, 17);
  endtask

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    unwrap_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result %0d arrived with nothing expected", result_index));
      end else begin
        want = expected_results.pop_front();
        compare_field("left_count", 64'(want.left_count), 64'(left_count_o));
        compare_field("right_count", 64'(want.right_count), 64'(right_count_o));
        compare_field("left_position", 64'(want.left_position), 64'(left_position_o));
        compare_field("right_position", 64'(want.right_position), 64'(right_position_o));
        compare_field("left_velocity", 64'(want.left_velocity), 64'(left_velocity_o));
        compare_field("right_velocity", 64'(want.right_velocity), 64'(right_velocity_o));
      end
      result_index++;
    end
  end

  // Any transfer on either side resets the count of quiet cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_defaults();
    test_register_extremes();
    test_full_turn_steps();
    test_back_pressure();
    test_random_traffic();
    in_valid_i <= 1'b0;
    for (int i = 0; i < IDLE_LIMIT && expected_results.size() != 0; i++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
